@@ hdl/key_velocity_curve_macros.svh @@
// assertion macros used by the checker of the key velocity block
`ifndef KEY_VELOCITY_CURVE_MACROS_SVH
`define KEY_VELOCITY_CURVE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define KVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define KVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kvc_pkg.sv @@
package kvc_pkg;

    // field widths
    localparam int NOTE_W  = 7;
    localparam int TICK_W  = 16;
    localparam int VEL_W   = 8;
    localparam int SCALE_W = 32;
    localparam int OFFS_W  = 24;
    localparam int BIAS_W  = 24;
    localparam int FRAC_W  = 8;

    // apb port
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int IDX_W   = PADDR_W - 2;

    // datapath widths
    localparam int D_W     = TICK_W + FRAC_W + 2;        // signed press divisor t*256+offset
    localparam int E_W     = D_W - 1;                    // positive divisor
    localparam int NUMB_W  = SCALE_W + FRAC_W;           // numerator base
    localparam int PROD_W  = BIAS_W + E_W + 1;           // bias times divisor
    localparam int NUM_W   = PROD_W + 1;                 // full numerator
    localparam int REM_W   = E_W + FRAC_W + VEL_W;       // remainder below 65536*den
    localparam int DIV_STEPS = VEL_W;

    // queue depth default
    localparam int QUEUE_DEPTH = 4;

    // key color
    localparam logic [11:0] BLACK_MASK = 12'hA52;
    localparam int NOTE_BASE = 21;
    localparam int OCTAVE    = 12;

    localparam logic [VEL_W-1:0] MAX_VEL_RESET = VEL_W'(127);

    typedef enum logic {
        KIND_PRESS   = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WHITE_SCALE       = 3'd0,
        REG_WHITE_OFFSET_TIME = 3'd1,
        REG_WHITE_BIAS        = 3'd2,
        REG_BLACK_SCALE       = 3'd3,
        REG_BLACK_OFFSET_TIME = 3'd4,
        REG_BLACK_BIAS        = 3'd5,
        REG_MAX_VELOCITY      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [SCALE_W-1:0] white_scale;
        logic signed [OFFS_W-1:0]  white_offset_time;
        logic signed [BIAS_W-1:0]  white_bias;
        logic signed [SCALE_W-1:0] black_scale;
        logic signed [OFFS_W-1:0]  black_offset_time;
        logic signed [BIAS_W-1:0]  black_bias;
        logic [VEL_W-1:0]          max_velocity;
    } kvc_cfg_t;

    // register values after reset
    localparam kvc_cfg_t CFG_RESET = '{max_velocity: MAX_VEL_RESET, default: '0};

    // classified job handed from front to back
    typedef struct packed {
        logic                     black_key;
        logic                     force_max;
        logic signed [NUMB_W-1:0] num_base;
        logic signed [BIAS_W-1:0] coef;
        logic [E_W-1:0]           divisor;
    } kvc_job_t;

    // black key flag for every note number, built at elaboration
    function automatic logic [(1 << NOTE_W)-1:0] black_note_map();
        logic [(1 << NOTE_W)-1:0] map;
        map = '0;
        for (int n = 0; n < (1 << NOTE_W); n++)
        begin
            map[n] = BLACK_MASK[(n + OCTAVE - (NOTE_BASE % OCTAVE)) % OCTAVE];
        end
        return map;
    endfunction

    localparam logic [(1 << NOTE_W)-1:0] BLACK_NOTES = black_note_map();

endpackage

@@ hdl/kvc_if.sv @@
// key event channel
interface kvc_in_if;
    import kvc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [NOTE_W-1:0] note_number;
    logic [TICK_W-1:0] tick_count;

    modport source (output valid, kind, note_number, tick_count, input ready);
    modport sink (input valid, kind, note_number, tick_count, output ready);
    modport monitor (input valid, ready, kind, note_number, tick_count);
endinterface

// velocity result channel
interface kvc_out_if;
    import kvc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VEL_W-1:0] velocity;
    logic             black_key;

    modport source (output valid, velocity, black_key, input ready);
    modport sink (input valid, velocity, black_key, output ready);
    modport monitor (input valid, ready, velocity, black_key);
endinterface

@@ hdl/kvc_cfg_regs.sv @@
module kvc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvc_pkg::PADDR_W-1:0]    paddr,
    input  logic [kvc_pkg::DATA_W-1:0]     pwdata,
    output logic [kvc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output kvc_pkg::kvc_cfg_t              cfg
);
    import kvc_pkg::*;

    kvc_cfg_t cfg_reg;
    kvc_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_WHITE_SCALE:       cfg_next.white_scale       = pwdata[SCALE_W-1:0];
                REG_WHITE_OFFSET_TIME: cfg_next.white_offset_time = pwdata[OFFS_W-1:0];
                REG_WHITE_BIAS:        cfg_next.white_bias        = pwdata[BIAS_W-1:0];
                REG_BLACK_SCALE:       cfg_next.black_scale       = pwdata[SCALE_W-1:0];
                REG_BLACK_OFFSET_TIME: cfg_next.black_offset_time = pwdata[OFFS_W-1:0];
                REG_BLACK_BIAS:        cfg_next.black_bias        = pwdata[BIAS_W-1:0];
                REG_MAX_VELOCITY:      cfg_next.max_velocity      = pwdata[VEL_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (idx)
            REG_WHITE_SCALE:       prdata = DATA_W'($unsigned(cfg_reg.white_scale));
            REG_WHITE_OFFSET_TIME: prdata = DATA_W'($unsigned(cfg_reg.white_offset_time));
            REG_WHITE_BIAS:        prdata = DATA_W'($unsigned(cfg_reg.white_bias));
            REG_BLACK_SCALE:       prdata = DATA_W'($unsigned(cfg_reg.black_scale));
            REG_BLACK_OFFSET_TIME: prdata = DATA_W'($unsigned(cfg_reg.black_offset_time));
            REG_BLACK_BIAS:        prdata = DATA_W'($unsigned(cfg_reg.black_bias));
            REG_MAX_VELOCITY:      prdata = DATA_W'(cfg_reg.max_velocity);
            default:               prdata = '0;
        endcase
    end

endmodule

@@ hdl/kvc_front.sv @@
module kvc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  kvc_pkg::kvc_cfg_t cfg,
    kvc_in_if.sink            key_in,
    output kvc_pkg::kvc_job_t job,
    output logic              job_valid,
    input  logic              job_ready
);
    import kvc_pkg::*;

    kvc_job_t                 job_reg;
    kvc_job_t                 job_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     load;
    logic                     black;
    logic signed [SCALE_W-1:0] scale;
    logic signed [OFFS_W-1:0] offs;
    logic signed [BIAS_W-1:0] bias;
    logic signed [D_W-1:0]    d;

    assign key_in.ready = !valid_reg || job_ready;
    assign load         = key_in.valid && key_in.ready;
    assign job          = job_reg;
    assign job_valid    = valid_reg;

    // key color and coefficient set
    assign black = BLACK_NOTES[key_in.note_number];
    assign scale = black ? cfg.black_scale : cfg.white_scale;
    assign offs  = black ? cfg.black_offset_time : cfg.white_offset_time;
    assign bias  = black ? cfg.black_bias : cfg.white_bias;

    // press divisor t*256 + offset
    assign d = $signed({2'b00, key_in.tick_count, {FRAC_W{1'b0}}}) + D_W'(offs);

    // classify the transaction into numerator and divisor terms
    always_comb
    begin
        job_next.black_key = black;
        if (key_in.kind == KIND_RELEASE)
        begin
            job_next.force_max = (key_in.tick_count == '0);
            job_next.num_base  = NUMB_W'(scale);
            job_next.coef      = '0;
            job_next.divisor   = E_W'(key_in.tick_count);
        end
        else
        begin
            job_next.force_max = d[D_W-1] || (d == '0);
            job_next.num_base  = {scale, {FRAC_W{1'b0}}};
            job_next.coef      = bias;
            job_next.divisor   = d[E_W-1:0];
        end
    end

    // valid flag of the front stage
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_next;
        end
    end

endmodule

@@ hdl/kvc_queue.sv @@
module kvc_queue #(
    parameter int DEPTH = kvc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kvc_pkg::kvc_job_t in_data,
    input  logic              in_valid,
    output logic              in_ready,
    output kvc_pkg::kvc_job_t out_data,
    output logic              out_valid,
    input  logic              out_ready
);
    import kvc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    kvc_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_COUNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ hdl/kvc_back.sv @@
module kvc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kvc_pkg::kvc_job_t             job,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [kvc_pkg::VEL_W-1:0]     max_velocity,
    kvc_out_if.source                     vel_out
);
    import kvc_pkg::*;

    // multiply, add, range check, one stage per quotient bit, clamp
    localparam int NSTAGE = 3 + DIV_STEPS + 1;
    localparam int OVER_SH = FRAC_W + VEL_W;

    typedef struct packed {
        logic             black_key;
        logic             force_max;
        logic             force_zero;
        logic [E_W-1:0]   divisor;
        logic [REM_W-1:0] rem;
        logic [VEL_W-1:0] quo;
    } div_t;

    logic [NSTAGE-1:0]        valid_reg;
    logic [NSTAGE-1:0]        valid_next;
    logic                     adv;

    logic                     s1_black_reg;
    logic                     s1_max_reg;
    logic signed [NUMB_W-1:0] s1_base_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [E_W-1:0]           s1_div_reg;
    logic signed [PROD_W-1:0] prod;

    logic                     s2_black_reg;
    logic                     s2_max_reg;
    logic signed [NUM_W-1:0]  s2_num_reg;
    logic [E_W-1:0]           s2_div_reg;
    logic signed [NUM_W-1:0]  num;

    logic                     over;
    div_t                     div_reg [DIV_STEPS+1];
    div_t                     div_next [DIV_STEPS+1];

    logic [VEL_W-1:0]         vel_reg;
    logic [VEL_W-1:0]         vel_next;
    logic                     black_reg;

    assign adv       = !valid_reg[NSTAGE-1] || vel_out.ready;
    assign job_ready = adv;

    // stage valid shift
    assign valid_next = {valid_reg[NSTAGE-2:0], job_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // bias times divisor
    assign prod = job.coef * $signed({1'b0, job.divisor});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_black_reg <= job.black_key;
            s1_max_reg   <= job.force_max;
            s1_base_reg  <= job.num_base;
            s1_prod_reg  <= prod;
            s1_div_reg   <= job.divisor;
        end
    end

    // full numerator
    assign num = NUM_W'(s1_base_reg) + NUM_W'(s1_prod_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_black_reg <= s1_black_reg;
            s2_max_reg   <= s1_max_reg;
            s2_num_reg   <= num;
            s2_div_reg   <= s1_div_reg;
        end
    end

    // quotient of 256 or more saturates, a negative numerator gives zero
    assign over = s2_num_reg[NUM_W-2:0] >=
                  (NUM_W-1)'({s2_div_reg, {OVER_SH{1'b0}}});

    always_comb
    begin
        div_next[0].black_key  = s2_black_reg;
        div_next[0].force_max  = s2_max_reg || (!s2_num_reg[NUM_W-1] && over);
        div_next[0].force_zero = !s2_max_reg && s2_num_reg[NUM_W-1];
        div_next[0].divisor    = s2_div_reg;
        div_next[0].rem        = s2_num_reg[REM_W-1:0];
        div_next[0].quo        = '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int SH = FRAC_W + DIV_STEPS - 1 - k;
        logic [REM_W-1:0] dshift;
        logic             ge;

        assign dshift = REM_W'(div_reg[k].divisor) << SH;
        assign ge     = div_reg[k].rem >= dshift;

        always_comb
        begin
            div_next[k+1]     = div_reg[k];
            div_next[k+1].rem = ge ? div_reg[k].rem - dshift : div_reg[k].rem;
            div_next[k+1].quo = {div_reg[k].quo[VEL_W-2:0], ge};
        end
    end

    for (genvar k = 0; k <= DIV_STEPS; k++)
    begin : g_div_reg
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // clamp into 0..max_velocity
    always_comb
    begin
        if (div_reg[DIV_STEPS].force_max)
        begin
            vel_next = max_velocity;
        end
        else if (div_reg[DIV_STEPS].force_zero)
        begin
            vel_next = '0;
        end
        else if (div_reg[DIV_STEPS].quo > max_velocity)
        begin
            vel_next = max_velocity;
        end
        else
        begin
            vel_next = div_reg[DIV_STEPS].quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vel_reg   <= vel_next;
            black_reg <= div_reg[DIV_STEPS].black_key;
        end
    end

    assign vel_out.valid     = valid_reg[NSTAGE-1];
    assign vel_out.velocity  = vel_reg;
    assign vel_out.black_key = black_reg;

endmodule

@@ hdl/key_velocity_curve.sv @@
// channel     | dir | handshake     | payload
// ------------+-----+---------------+----------------------------------------
// key_in      | in  | valid / ready | kind, note_number, tick_count
// vel_out     | out | valid / ready | velocity, black_key
// apb config  | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// one transaction per cycle sustained while vel_out is ready; the path from key_in
// acceptance to vel_out valid is the front register, the queue and 12 back stages
// the back pipeline steps once per quotient bit through a restoring divider
// rst_n is asynchronous; max_velocity resets to 127, other registers to zero
// a vel_out stall freezes the back pipeline; the queue and the front
// register keep taking transactions until they fill
module key_velocity_curve #(
    parameter int QUEUE_DEPTH = kvc_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvc_pkg::PADDR_W-1:0]    paddr,
    input  logic [kvc_pkg::DATA_W-1:0]     pwdata,
    output logic [kvc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    kvc_in_if.sink                         key_in,
    kvc_out_if.source                      vel_out
);
    import kvc_pkg::*;

    kvc_cfg_t cfg;
    kvc_job_t front_job;
    logic     front_valid;
    logic     front_ready;
    kvc_job_t back_job;
    logic     back_valid;
    logic     back_ready;

    // configuration registers
    kvc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classify key events
    kvc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .key_in    (key_in),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    // decoupling queue
    kvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (front_job),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (back_job),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    // divide and clamp
    kvc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (back_job),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .max_velocity (cfg.max_velocity),
        .vel_out      (vel_out)
    );

endmodule

@@ hdl/kvc_checker.sv @@
`include "key_velocity_curve_macros.svh"

module kvc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvc_pkg::PADDR_W-1:0]    paddr,
    input  logic [kvc_pkg::DATA_W-1:0]     pwdata,
    input  logic                           pready,
    input  logic                           key_valid,
    input  logic                           key_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [kvc_pkg::VEL_W-1:0]      velocity,
    input  logic                           black_key
);
    import kvc_pkg::*;

    logic [15:0]      pending_reg;
    logic [15:0]      pending_next;
    logic [VEL_W-1:0] max_reg;
    logic [VEL_W-1:0] max_next;
    logic             in_acc;
    logic             out_acc;
    logic             max_wr;
    logic             stall;
    logic             idle;
    logic [VEL_W:0]   out_data;

    assign in_acc   = key_valid && key_ready;
    assign out_acc  = out_valid && out_ready;
    assign stall    = out_valid && !out_ready;
    assign idle     = (pending_reg == '0);
    assign out_data = {black_key, velocity};
    assign max_wr   = psel && penable && pwrite && pready &&
                      (reg_idx_t'(paddr[PADDR_W-1:2]) == REG_MAX_VELOCITY);

    // transactions in flight and shadow of the clamp register
    always_comb
    begin
        pending_next = pending_reg + 16'(in_acc) - 16'(out_acc);
        max_next     = max_wr ? pwdata[VEL_W-1:0] : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            max_reg     <= MAX_VEL_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            max_reg     <= max_next;
        end
    end

    `KVC_ASSERT_NXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(out_data), "stall broken")
    `KVC_ASSERT_IMP(a_no_extra, clk, rst_n, out_valid, !idle, "result with nothing pending")
    `KVC_ASSERT_IMP(a_empty_ready, clk, rst_n, idle, key_ready, "idle block refuses input")
    `KVC_ASSERT_IMP(a_vel_clamp, clk, rst_n, out_valid, velocity <= max_reg, "above clamp")

endmodule

bind key_velocity_curve kvc_checker u_kvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .key_valid (key_in.valid),
    .key_ready (key_in.ready),
    .out_valid (vel_out.valid),
    .out_ready (vel_out.ready),
    .velocity  (vel_out.velocity),
    .black_key (vel_out.black_key)
);

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kvc_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int IDLE_PERCENT    = 34;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int STEADY_FROM     = 1000;
    localparam int STEADY_TO       = 1300;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        kind_t             kind;
        logic [NOTE_W-1:0] note;
        logic [TICK_W-1:0] ticks;
    } key_event_t;

    typedef struct {
        logic [VEL_W-1:0] velocity;
        logic             black_key;
    } key_velocity_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    kvc_in_if  key_in ();
    kvc_out_if vel_out ();

    // curve registers as the block should hold them
    kvc_cfg_t curve;

    key_event_t    key_events[$];
    key_velocity_t vel_expected[$];

    int   rx_count    = 0;
    int   error_count = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;
    logic steady;

    assign steady = (rx_count >= STEADY_FROM) && (rx_count < STEADY_TO);

    key_velocity_curve dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key_in  (key_in),
        .vel_out (vel_out)
    );

    always #HALF_PERIOD clk = ~clk;

    // velocity a key event should produce under the current curve
    function automatic key_velocity_t predict_velocity(kind_t kind, logic [NOTE_W-1:0] note,
                                                       logic [TICK_W-1:0] ticks);
        key_velocity_t r;
        int            pos;
        longint        scale;
        longint        offs;
        longint        bias;
        longint        t;
        longint        d;
        longint        q;
        longint        top;
        logic          saturate;
        pos = (int'(note) + OCTAVE - NOTE_BASE % OCTAVE) % OCTAVE;
        r.black_key = BLACK_MASK[pos];
        scale = r.black_key ? $signed(curve.black_scale) : $signed(curve.white_scale);
        offs = r.black_key ? $signed(curve.black_offset_time)
                           : $signed(curve.white_offset_time);
        bias = r.black_key ? $signed(curve.black_bias) : $signed(curve.white_bias);
        t = longint'(ticks);
        top = longint'(curve.max_velocity);
        saturate = 1'b0;
        q = 0;
        if (kind == KIND_PRESS)
        begin
            // scale/d + bias/256 combined over one denominator, truncated once
            d = t * 256 + offs;
            if (d <= 0)
                saturate = 1'b1;
            else
                q = (scale * 256 + bias * d) / (d * 256);
        end
        else if (t == 0)
            saturate = 1'b1;
        else
            q = scale / (t * 256);
        if (saturate || q > top)
            r.velocity = curve.max_velocity;
        else if (q < 0)
            r.velocity = '0;
        else
            r.velocity = VEL_W'(q);
        return r;
    endfunction

    // register write with a setup and an access phase, mirrored into the predictor's copy
    task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WHITE_SCALE:       curve.white_scale       = value[SCALE_W-1:0];
            REG_WHITE_OFFSET_TIME: curve.white_offset_time = value[OFFS_W-1:0];
            REG_WHITE_BIAS:        curve.white_bias        = value[BIAS_W-1:0];
            REG_BLACK_SCALE:       curve.black_scale       = value[SCALE_W-1:0];
            REG_BLACK_OFFSET_TIME: curve.black_offset_time = value[OFFS_W-1:0];
            REG_BLACK_BIAS:        curve.black_bias        = value[BIAS_W-1:0];
            REG_MAX_VELOCITY:      curve.max_velocity      = value[VEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_curve(kvc_cfg_t c);
        write_register(REG_WHITE_SCALE, DATA_W'($signed(c.white_scale)));
        write_register(REG_WHITE_OFFSET_TIME, DATA_W'($signed(c.white_offset_time)));
        write_register(REG_WHITE_BIAS, DATA_W'($signed(c.white_bias)));
        write_register(REG_BLACK_SCALE, DATA_W'($signed(c.black_scale)));
        write_register(REG_BLACK_OFFSET_TIME, DATA_W'($signed(c.black_offset_time)));
        write_register(REG_BLACK_BIAS, DATA_W'($signed(c.black_bias)));
        write_register(REG_MAX_VELOCITY, DATA_W'(c.max_velocity));
    endtask

    task automatic add_key(kind_t kind, int note, int ticks);
        key_event_t ev;
        ev.kind  = kind;
        ev.note  = NOTE_W'(note);
        ev.ticks = TICK_W'(ticks);
        key_events.push_back(ev);
    endtask

    // block is quiet once everything queued was accepted and answered
    task automatic wait_idle();
        @(negedge clk);
        while (key_events.size() != 0 || key_in.valid || vel_expected.size() != 0)
            @(negedge clk);
    endtask

    // playable curve or raw register noise
    function automatic kvc_cfg_t random_curve(bit playable);
        kvc_cfg_t c;
        if (playable)
        begin
            c.white_scale = SCALE_W'($urandom_range(5000, 300000) * 256 + $urandom_range(0, 255));
            c.black_scale = SCALE_W'($urandom_range(5000, 300000) * 256 + $urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                c.white_scale = -c.white_scale;
            if ($urandom_range(0, 7) == 0)
                c.black_scale = -c.black_scale;
            c.white_offset_time = OFFS_W'($urandom_range(0, 2 * 256 * 300) - 256 * 300);
            c.black_offset_time = OFFS_W'($urandom_range(0, 2 * 256 * 300) - 256 * 300);
            c.white_bias = BIAS_W'($urandom_range(0, 256 * 60) - 256 * 30);
            c.black_bias = BIAS_W'($urandom_range(0, 256 * 60) - 256 * 30);
            c.max_velocity = ($urandom_range(0, 3) == 0) ? VEL_W'($urandom_range(0, 255))
                                                         : MAX_VEL_RESET;
        end
        else
        begin
            c.white_scale       = SCALE_W'($urandom);
            c.white_offset_time = OFFS_W'($urandom);
            c.white_bias        = BIAS_W'($urandom);
            c.black_scale       = SCALE_W'($urandom);
            c.black_offset_time = OFFS_W'($urandom);
            c.black_bias        = BIAS_W'($urandom);
            c.max_velocity      = VEL_W'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // travel times mostly in the playable range, some short, some anywhere
    function automatic key_event_t random_key();
        key_event_t ev;
        int         pick;
        pick = $urandom_range(0, 99);
        ev.kind = kind_t'($urandom_range(0, 1));
        ev.note = NOTE_W'($urandom_range(0, 127));
        if (pick < 50)
            ev.ticks = TICK_W'($urandom_range(0, 3000));
        else if (pick < 70)
            ev.ticks = TICK_W'($urandom_range(0, 255));
        else if (pick < 95)
            ev.ticks = TICK_W'($urandom);
        else
            case ($urandom_range(0, 2))
                0: ev.ticks = '0;
                1: ev.ticks = TICK_W'(1);
                default: ev.ticks = '1;
            endcase
        return ev;
    endfunction

    // key event driver, predicts on every accepted transaction
    always @(posedge clk)
    begin : drive_keys
        key_event_t ev;
        if (rst_n)
        begin
            if (key_in.valid && key_in.ready)
                vel_expected.push_back(predict_velocity(kind_t'(key_in.kind), key_in.note_number,
                                                        key_in.tick_count));
            if (!key_in.valid || key_in.ready)
            begin
                if (key_events.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    ev = key_events.pop_front();
                    key_in.valid       <= 1'b1;
                    key_in.kind        <= ev.kind;
                    key_in.note_number <= ev.note;
                    key_in.tick_count  <= ev.ticks;
                end
                else
                    key_in.valid <= 1'b0;
            end
        end
    end

    // one long hold-off so the block backs up into its input
    always @(posedge clk)
    begin : hold_off
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && rx_count >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // velocity monitor and receiver back-pressure
    always @(posedge clk)
    begin : watch_velocity
        key_velocity_t want;
        if (rst_n)
        begin
            if (vel_out.valid && vel_out.ready)
            begin
                rx_count <= rx_count + 1;
                if (vel_expected.size() == 0)
                begin
                    $display("%0t: unexpected velocity transaction %0d black_key %0b",
                             $realtime, vel_out.velocity, vel_out.black_key);
                    error_count++;
                end
                else
                begin
                    want = vel_expected.pop_front();
                    if (vel_out.velocity !== want.velocity)
                    begin
                        $display("%0t: velocity mismatch, expected %0d, actual %0d",
                                 $realtime, want.velocity, vel_out.velocity);
                        error_count++;
                    end
                    if (vel_out.black_key !== want.black_key)
                    begin
                        $display("%0t: black_key mismatch, expected %0b, actual %0b",
                                 $realtime, want.black_key, vel_out.black_key);
                        error_count++;
                    end
                end
            end
            if (hold_left != 0 || (!hold_done && rx_count >= HOLD_AFTER))
                vel_out.ready <= 1'b0;
            else
                vel_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : stimulus
        kvc_cfg_t c;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        key_in.valid       = 1'b0;
        key_in.kind        = KIND_PRESS;
        key_in.note_number = '0;
        key_in.tick_count  = '0;
        vel_out.ready      = 1'b0;
        curve              = '0;
        curve.max_velocity = MAX_VEL_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients: only the divisor guard can lift the velocity
        @(negedge clk);
        add_key(KIND_PRESS, 21, 0);
        add_key(KIND_PRESS, 60, 65535);
        add_key(KIND_RELEASE, 61, 0);
        add_key(KIND_RELEASE, 22, 1);
        wait_idle();

        // hand-picked curve around the divisor, clamp and key color edges
        c = '0;
        c.white_scale       = 63500 * 256;
        c.white_offset_time = -100 * 256;
        c.white_bias        = -10 * 256;
        c.black_scale       = 80000 * 256;
        c.black_offset_time = 50 * 256;
        c.black_bias        = 5 * 256;
        c.max_velocity      = MAX_VEL_RESET;
        load_curve(c);
        @(negedge clk);
        add_key(KIND_PRESS, 21, 0);
        add_key(KIND_PRESS, 21, 99);
        add_key(KIND_PRESS, 21, 100);
        add_key(KIND_PRESS, 21, 101);
        add_key(KIND_PRESS, 21, 600);
        add_key(KIND_PRESS, 21, 65535);
        add_key(KIND_PRESS, 22, 1000);
        add_key(KIND_PRESS, 0, 600);
        add_key(KIND_PRESS, 1, 1000);
        add_key(KIND_PRESS, 20, 1000);
        add_key(KIND_PRESS, 127, 600);
        add_key(KIND_RELEASE, 21, 0);
        add_key(KIND_RELEASE, 21, 1);
        add_key(KIND_RELEASE, 21, 500);
        add_key(KIND_RELEASE, 21, 65535);
        add_key(KIND_RELEASE, 22, 1000);
        add_key(KIND_RELEASE, 127, 800);
        add_key(KIND_RELEASE, 0, 800);
        wait_idle();

        // random traffic, one curve per phase, register extremes first
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    c.white_scale       = 32'sh7FFF_FFFF;
                    c.white_offset_time = 24'sh7F_FFFF;
                    c.white_bias        = 24'sh7F_FFFF;
                    c.black_scale       = 32'sh7FFF_FFFF;
                    c.black_offset_time = 24'sh7F_FFFF;
                    c.black_bias        = 24'sh7F_FFFF;
                    c.max_velocity      = 8'hFF;
                end
                1:
                begin
                    c.white_scale       = 32'sh8000_0000;
                    c.white_offset_time = 24'sh80_0000;
                    c.white_bias        = 24'sh80_0000;
                    c.black_scale       = 32'sh8000_0000;
                    c.black_offset_time = 24'sh80_0000;
                    c.black_bias        = 24'sh80_0000;
                    c.max_velocity      = 8'h00;
                end
                2:
                begin
                    c.white_scale       = 32'sh7FFF_FFFF;
                    c.white_offset_time = 24'sh80_0000;
                    c.white_bias        = 24'sh7F_FFFF;
                    c.black_scale       = 32'sh8000_0000;
                    c.black_offset_time = 24'sh7F_FFFF;
                    c.black_bias        = 24'sh80_0000;
                    c.max_velocity      = 8'hFF;
                end
                default:
                    c = random_curve(p % 2 == 1);
            endcase
            load_curve(c);
            @(negedge clk);
            repeat (ITEMS_PER_PHASE) key_events.push_back(random_key());
            wait_idle();
        end

        // let anything stray show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
